/* rtl/core/sst_pkg.sv */
// Shared types, constants and codes of the semaphore set table.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

  localparam int NUM_SETS_DEF     = 32;
  localparam int SEMS_PER_SET_DEF = 32;
  localparam int MAX_OPS_DEF      = 32;

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_OP     = 3'd1,
    MODE_SET    = 3'd2,
    MODE_GET    = 3'd3,
    MODE_REMOVE = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_INDEX     = 3'd4,
    ST_AGAIN     = 3'd5,
    ST_BLOCK     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_IDENT,
    VAL_NEXT,
    VAL_SEM
  } val_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_KEY_SCAN,
    S_KEY_MISS,
    S_FREE_SCAN,
    S_CLEAR,
    S_ID_SCAN,
    S_ID_HIT,
    S_SEM_WAIT,
    S_CHK_RD,
    S_CHK_IDX,
    S_CHK_EVAL,
    S_APP_RD,
    S_APP_IDX,
    S_APP_EVAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic        create_flag;
    logic [5:0]  set_size;
    logic [30:0] set_id;
    logic [5:0]  sem_index;
    logic [15:0] sem_delta;
    logic        no_wait;
    logic        last_op;
    logic [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic        no_wait;
    logic [15:0] delta;
    logic [5:0]  idx;
  } op_t;

  typedef struct packed {
    logic     load;
    logic     scan_clr;
    logic     scan_inc;
    logic     hit_take;
    logic     op_push;
    logic     op_ovf_set;
    logic     group_clr;
    logic     ptr_clr;
    logic     ptr_inc;
    logic     rd_op;
    logic     rd_sem;
    logic     rd_sem_op;
    logic     wr_zero;
    logic     wr_new;
    logic     wr_sum;
    logic     fail_clr;
    logic     fail_acc;
    logic     entry_create;
    logic     entry_remove;
    logic     res_set;
    status_t  res_status;
    val_sel_t res_sel;
    logic     res_push;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       size_big;
    logic       size_zero;
    logic       key_zero;
    logic       create_flag;
    logic       last_op;
    logic       ovf;
    logic       op_full;
    logic       scan_end;
    logic       key_hit;
    logic       id_hit;
    logic       free_hit;
    logic       ptr_last;
    logic       clr_end;
    logic       idx_bad;
    logic       op_idx_bad;
    logic       chk_fail;
    logic       nw_any;
    logic       res_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/sst_in_if.sv */
// Request channel of the semaphore set table.
`timescale 1ns / 1ps
`default_nettype none
interface sst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] key;
  logic        create_flag;
  logic [5:0]  set_size;
  logic [30:0] set_id;
  logic [5:0]  sem_index;
  logic [15:0] sem_delta;
  logic        no_wait;
  logic        last_op;
  logic [31:0] new_value;

  modport source (output valid, mode, key, create_flag, set_size, set_id, sem_index,
                  sem_delta, no_wait, last_op, new_value, input ready);
  modport sink (input valid, mode, key, create_flag, set_size, set_id, sem_index,
                sem_delta, no_wait, last_op, new_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/sst_out_if.sv */
// Response channel of the semaphore set table.
`timescale 1ns / 1ps
`default_nettype none
interface sst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value;

  modport source (output valid, status, value, input ready);
  modport sink (input valid, status, value, output ready);
endinterface
`default_nettype wire

/* rtl/core/sst_ctrl.sv */
// Controller state machine of the semaphore set table.
`timescale 1ns / 1ps
`default_nettype none
module sst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  sst_pkg::sts_t      sts,
  output sst_pkg::cmd_t      cmd
);

  sst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_status = sst_pkg::ST_OK;
    cmd.res_sel = sst_pkg::VAL_ZERO;
    req_ready = 1'b0;
    case (state)
      sst_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = sst_pkg::S_DISPATCH;
        end
      end
      sst_pkg::S_DISPATCH: begin
        case (sts.mode)
          sst_pkg::MODE_CREATE: begin
            if (sts.size_big) begin
              cmd.res_set = 1'b1;
              cmd.res_status = sst_pkg::ST_INVALID;
              state_next = sst_pkg::S_EMIT;
            end else if (sts.key_zero) begin
              state_next = sst_pkg::S_KEY_MISS;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next = sst_pkg::S_KEY_SCAN;
            end
          end
          sst_pkg::MODE_OP: begin
            if (sts.op_full) begin
              cmd.op_ovf_set = 1'b1;
            end else begin
              cmd.op_push = 1'b1;
            end
            if (!sts.last_op) begin
              state_next = sst_pkg::S_IDLE;
            end else if (sts.ovf || sts.op_full) begin
              cmd.group_clr = 1'b1;
              cmd.res_set = 1'b1;
              cmd.res_status = sst_pkg::ST_INVALID;
              state_next = sst_pkg::S_EMIT;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next = sst_pkg::S_ID_SCAN;
            end
          end
          sst_pkg::MODE_SET, sst_pkg::MODE_GET, sst_pkg::MODE_REMOVE: begin
            cmd.scan_clr = 1'b1;
            state_next = sst_pkg::S_ID_SCAN;
          end
          default: begin
            cmd.res_set = 1'b1;
            cmd.res_status = sst_pkg::ST_INVALID;
            state_next = sst_pkg::S_EMIT;
          end
        endcase
      end
      sst_pkg::S_KEY_SCAN: begin
        if (sts.key_hit) begin
          cmd.hit_take = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_sel = sst_pkg::VAL_IDENT;
          state_next = sst_pkg::S_EMIT;
        end else if (sts.scan_end) begin
          state_next = sst_pkg::S_KEY_MISS;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      sst_pkg::S_KEY_MISS: begin
        if (!sts.key_zero && !sts.create_flag) begin
          cmd.res_set = 1'b1;
          cmd.res_status = sst_pkg::ST_NOT_FOUND;
          state_next = sst_pkg::S_EMIT;
        end else if (sts.size_zero) begin
          cmd.res_set = 1'b1;
          cmd.res_status = sst_pkg::ST_INVALID;
          state_next = sst_pkg::S_EMIT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next = sst_pkg::S_FREE_SCAN;
        end
      end
      sst_pkg::S_FREE_SCAN: begin
        if (sts.free_hit) begin
          cmd.hit_take = 1'b1;
          cmd.ptr_clr = 1'b1;
          state_next = sst_pkg::S_CLEAR;
        end else if (sts.scan_end) begin
          cmd.res_set = 1'b1;
          cmd.res_status = sst_pkg::ST_NO_SPACE;
          state_next = sst_pkg::S_EMIT;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      sst_pkg::S_CLEAR: begin
        cmd.wr_zero = 1'b1;
        if (sts.clr_end) begin
          cmd.entry_create = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_sel = sst_pkg::VAL_NEXT;
          state_next = sst_pkg::S_EMIT;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      sst_pkg::S_ID_SCAN: begin
        if (sts.id_hit) begin
          cmd.hit_take = 1'b1;
          state_next = sst_pkg::S_ID_HIT;
        end else if (sts.scan_end) begin
          cmd.group_clr = (sts.mode == sst_pkg::MODE_OP);
          cmd.res_set = 1'b1;
          cmd.res_status = sst_pkg::ST_INVALID;
          state_next = sst_pkg::S_EMIT;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      sst_pkg::S_ID_HIT: begin
        if (sts.mode == sst_pkg::MODE_OP) begin
          cmd.ptr_clr = 1'b1;
          cmd.fail_clr = 1'b1;
          state_next = sst_pkg::S_CHK_RD;
        end else if (sts.mode == sst_pkg::MODE_REMOVE) begin
          cmd.entry_remove = 1'b1;
          cmd.res_set = 1'b1;
          state_next = sst_pkg::S_EMIT;
        end else if (sts.idx_bad) begin
          cmd.res_set = 1'b1;
          cmd.res_status = sst_pkg::ST_INVALID;
          state_next = sst_pkg::S_EMIT;
        end else if (sts.mode == sst_pkg::MODE_SET) begin
          cmd.wr_new = 1'b1;
          cmd.res_set = 1'b1;
          state_next = sst_pkg::S_EMIT;
        end else begin
          cmd.rd_sem = 1'b1;
          state_next = sst_pkg::S_SEM_WAIT;
        end
      end
      sst_pkg::S_SEM_WAIT: begin
        cmd.res_set = 1'b1;
        cmd.res_sel = sst_pkg::VAL_SEM;
        state_next = sst_pkg::S_EMIT;
      end
      sst_pkg::S_CHK_RD: begin
        cmd.rd_op = 1'b1;
        state_next = sst_pkg::S_CHK_IDX;
      end
      sst_pkg::S_CHK_IDX: begin
        if (sts.op_idx_bad) begin
          cmd.group_clr = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_status = sst_pkg::ST_INDEX;
          state_next = sst_pkg::S_EMIT;
        end else begin
          cmd.rd_sem = 1'b1;
          cmd.rd_sem_op = 1'b1;
          state_next = sst_pkg::S_CHK_EVAL;
        end
      end
      sst_pkg::S_CHK_EVAL: begin
        cmd.fail_acc = 1'b1;
        if (!sts.ptr_last) begin
          cmd.ptr_inc = 1'b1;
          state_next = sst_pkg::S_CHK_RD;
        end else if (sts.chk_fail) begin
          cmd.group_clr = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_status = sts.nw_any ? sst_pkg::ST_AGAIN : sst_pkg::ST_BLOCK;
          state_next = sst_pkg::S_EMIT;
        end else begin
          cmd.ptr_clr = 1'b1;
          state_next = sst_pkg::S_APP_RD;
        end
      end
      sst_pkg::S_APP_RD: begin
        cmd.rd_op = 1'b1;
        state_next = sst_pkg::S_APP_IDX;
      end
      sst_pkg::S_APP_IDX: begin
        cmd.rd_sem = 1'b1;
        cmd.rd_sem_op = 1'b1;
        state_next = sst_pkg::S_APP_EVAL;
      end
      sst_pkg::S_APP_EVAL: begin
        cmd.wr_sum = 1'b1;
        if (sts.ptr_last) begin
          cmd.group_clr = 1'b1;
          cmd.res_set = 1'b1;
          state_next = sst_pkg::S_EMIT;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next = sst_pkg::S_APP_RD;
        end
      end
      sst_pkg::S_EMIT: begin
        if (sts.res_free) begin
          cmd.res_push = 1'b1;
          state_next = sst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sst_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/sst_datapath.sv */
// Datapath of the semaphore set table: set entries, counter memory, op buffer, result register.
`timescale 1ns / 1ps
`default_nettype none
module sst_datapath #(
  parameter int NUM_SETS     = sst_pkg::NUM_SETS_DEF,
  parameter int SEMS_PER_SET = sst_pkg::SEMS_PER_SET_DEF,
  parameter int MAX_OPS      = sst_pkg::MAX_OPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  sst_pkg::in_item_t     item,
  input  sst_pkg::cmd_t         cmd,
  output sst_pkg::sts_t         sts,
  input  wire logic             rsp_ready,
  output logic                  rsp_valid,
  output logic [2:0]            rsp_status,
  output logic [31:0]           rsp_value
);

  localparam int DEPTH = NUM_SETS * SEMS_PER_SET;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = AW + 6;
  localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int OW    = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int CW    = $clog2(MAX_OPS + 1);
  localparam int PMAX  = (MAX_OPS > SEMS_PER_SET) ? MAX_OPS : SEMS_PER_SET;
  localparam int PW    = $clog2(PMAX + 1);

  sst_pkg::in_item_t in_q;

  logic [NUM_SETS-1:0] used;
  logic [31:0]         set_key   [NUM_SETS];
  logic [31:0]         set_ident [NUM_SETS];
  logic [5:0]          set_count [NUM_SETS];
  logic [31:0]         next_id;

  logic [31:0]         sem_mem [DEPTH];
  logic [31:0]         sem_q;
  sst_pkg::op_t        op_mem [MAX_OPS];
  sst_pkg::op_t        op_q;

  logic [CW-1:0]       op_count;
  logic                ovf;
  logic [SW-1:0]       scan;
  logic [SW-1:0]       hit;
  logic [AW-1:0]       base;
  logic [PW-1:0]       ptr;
  logic                fail;
  logic                nw;

  logic [2:0]          pend_status;
  logic [31:0]         pend_value;

  logic [PW:0]         ptr_plus;
  logic [XW-1:0]       addr_in, addr_op, addr_ptr;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [31:0]         wr_data;
  logic                wr_en;
  logic [32:0]         chk_sum;
  logic                cur_fail;
  logic [31:0]         val_mux;

  assign ptr_plus = {1'b0, ptr} + 1'b1;
  assign addr_in  = {6'd0, base} + XW'(in_q.sem_index);
  assign addr_op  = {6'd0, base} + XW'(op_q.idx);
  assign addr_ptr = {6'd0, base} + XW'(ptr);
  assign rd_addr  = cmd.rd_sem_op ? addr_op[AW-1:0] : addr_in[AW-1:0];

  assign chk_sum  = {sem_q[31], sem_q} + {{17{op_q.delta[15]}}, op_q.delta};
  assign cur_fail = (op_q.delta[15] && chk_sum[32]) ||
                    ((op_q.delta == 16'd0) && (sem_q != 32'd0));

  always_comb begin
    wr_en   = cmd.wr_zero || cmd.wr_new || cmd.wr_sum;
    wr_addr = addr_ptr[AW-1:0];
    wr_data = 32'd0;
    if (cmd.wr_new) begin
      wr_addr = addr_in[AW-1:0];
      wr_data = in_q.new_value;
    end else if (cmd.wr_sum) begin
      wr_addr = addr_op[AW-1:0];
      wr_data = sem_q + {{16{op_q.delta[15]}}, op_q.delta};
    end
  end

  always_comb begin
    case (cmd.res_sel)
      sst_pkg::VAL_IDENT: val_mux = set_ident[scan];
      sst_pkg::VAL_NEXT:  val_mux = next_id;
      sst_pkg::VAL_SEM:   val_mux = sem_q;
      default:            val_mux = 32'd0;
    endcase
  end

  always_comb begin
    sts.mode        = in_q.mode;
    sts.size_big    = {26'd0, in_q.set_size} > 32'(SEMS_PER_SET);
    sts.size_zero   = (in_q.set_size == 6'd0);
    sts.key_zero    = (in_q.key == 32'd0);
    sts.create_flag = in_q.create_flag;
    sts.last_op     = in_q.last_op;
    sts.ovf         = ovf;
    sts.op_full     = (op_count == CW'(MAX_OPS));
    sts.scan_end    = (scan == SW'(NUM_SETS - 1));
    sts.key_hit     = used[scan] && (set_key[scan] == in_q.key);
    sts.id_hit      = used[scan] && (set_ident[scan] == {1'b0, in_q.set_id});
    sts.free_hit    = !used[scan];
    sts.ptr_last    = (ptr_plus == (PW + 1)'(op_count));
    sts.clr_end     = (ptr == PW'(SEMS_PER_SET - 1));
    sts.idx_bad     = (in_q.sem_index >= set_count[hit]);
    sts.op_idx_bad  = (op_q.idx >= set_count[hit]);
    sts.chk_fail    = fail || cur_fail;
    sts.nw_any      = nw || (cur_fail && op_q.no_wait);
    sts.res_free    = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= item;
    end
    if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + 1'b1;
    end
    if (cmd.hit_take) begin
      hit  <= scan;
      base <= AW'(scan * SEMS_PER_SET);
    end
    if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_plus[PW-1:0];
    end
    if (cmd.fail_clr) begin
      fail <= 1'b0;
      nw   <= 1'b0;
    end else if (cmd.fail_acc) begin
      fail <= fail || cur_fail;
      nw   <= nw || (cur_fail && op_q.no_wait);
    end
    if (cmd.entry_create) begin
      set_key[hit]   <= in_q.key;
      set_ident[hit] <= next_id;
      set_count[hit] <= in_q.set_size;
    end
    if (cmd.res_set) begin
      pend_status <= cmd.res_status;
      pend_value  <= val_mux;
    end
    if (cmd.op_push) begin
      op_mem[op_count[OW-1:0]] <= '{no_wait: in_q.no_wait, delta: in_q.sem_delta,
                                    idx: in_q.sem_index};
    end
    if (cmd.rd_op) begin
      op_q <= op_mem[ptr[OW-1:0]];
    end
    if (wr_en) begin
      sem_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_sem) begin
      sem_q <= sem_mem[rd_addr];
    end
    if (cmd.res_push) begin
      rsp_status <= pend_status;
      rsp_value  <= pend_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      next_id   <= 32'd1;
      op_count  <= '0;
      ovf       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.entry_create) begin
        used[hit] <= 1'b1;
        next_id   <= next_id + 32'd1;
      end else if (cmd.entry_remove) begin
        used[hit] <= 1'b0;
      end
      if (cmd.group_clr) begin
        op_count <= '0;
        ovf      <= 1'b0;
      end else if (cmd.op_push) begin
        op_count <= op_count + 1'b1;
      end else if (cmd.op_ovf_set) begin
        ovf <= 1'b1;
      end
      if (cmd.res_push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/semaphore_set_table_top.sv */
// Top level of the semaphore set table: controller and datapath joined to the channels.
//
// The block keeps up to NUM_SETS semaphore sets of up to SEMS_PER_SET 32-bit counters.
// Requests arrive on the req channel, one beat per command; results leave on the rsp
// channel, at most one beat per request. An op element that is not the last of its group
// is only buffered and gives no response beat.
// The steps depend on the command. A request is loaded and then dispatched; a lookup then
// walks the set entries one per cycle, over up to NUM_SETS entries. Creating a set adds a
// clearing sweep over all SEMS_PER_SET counters of the set in the counter memory. The last
// op element of a group walks the buffered ops twice, checking and then applying; each op
// reads the op buffer, then the counter memory, then evaluates the counter with its delta.
// Only one request is in flight at a time; req.ready is high while the controller is idle.
// The response sits in an output register, so a new request is taken while a finished
// response still waits for rsp.ready; a second result then waits inside the block.
// A synchronous reset empties the table, the op buffer and the output register, and sets
// the next set identifier to one. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module semaphore_set_table_top #(
  parameter int NUM_SETS     = sst_pkg::NUM_SETS_DEF,
  parameter int SEMS_PER_SET = sst_pkg::SEMS_PER_SET_DEF,
  parameter int MAX_OPS      = sst_pkg::MAX_OPS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  sst_in_if.sink     req,
  sst_out_if.source  rsp
);

  sst_pkg::cmd_t     cmd;
  sst_pkg::sts_t     sts;
  sst_pkg::in_item_t item;
  logic              ready;

  // Gather the request payload into one word for the datapath.
  assign item = '{mode: req.mode, key: req.key, create_flag: req.create_flag,
                  set_size: req.set_size, set_id: req.set_id, sem_index: req.sem_index,
                  sem_delta: req.sem_delta, no_wait: req.no_wait, last_op: req.last_op,
                  new_value: req.new_value};
  assign req.ready = ready;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sst_datapath #(
    .NUM_SETS     (NUM_SETS),
    .SEMS_PER_SET (SEMS_PER_SET),
    .MAX_OPS      (MAX_OPS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cmd        (cmd),
    .sts        (sts),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rsp_status (rsp.status),
    .rsp_value  (rsp.value)
  );

endmodule
`default_nettype wire
